/* rtl/tkis_pkg.sv */
// Package with the sizes, record type and cell control type of the record sorter.
package tkis_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int POST_W      = 20;
  localparam int NUMBER_W    = 37;
  localparam int TAG_W       = 16;

  typedef struct packed {
    logic [POST_W-1:0]   post;
    logic [NUMBER_W-1:0] number;
    logic [TAG_W-1:0]    tag;
  } record_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

/* rtl/tkis_in_if.sv */
// Handshake channel that carries one input record word.
interface tkis_in_if;
  logic                          valid;
  logic                          ready;
  logic [tkis_pkg::POST_W-1:0]   post_code;
  logic [tkis_pkg::NUMBER_W-1:0] phone_number;
  logic [tkis_pkg::TAG_W-1:0]    payload_tag;
  logic                          last_record;

  modport source (output valid, post_code, phone_number, payload_tag, last_record,
                  input ready);
  modport sink (input valid, post_code, phone_number, payload_tag, last_record,
                output ready);
endinterface

/* rtl/tkis_out_if.sv */
// Handshake channel that carries one sorted result word.
interface tkis_out_if;
  logic                          valid;
  logic                          ready;
  logic [tkis_pkg::POST_W-1:0]   post_code_res;
  logic [tkis_pkg::NUMBER_W-1:0] phone_number_res;
  logic [tkis_pkg::TAG_W-1:0]    payload_tag_res;
  logic                          last_out;
  logic                          overflowed;

  modport source (output valid, post_code_res, phone_number_res, payload_tag_res,
                  last_out, overflowed, input ready);
  modport sink (input valid, post_code_res, phone_number_res, payload_tag_res,
                last_out, overflowed, output ready);
endinterface

/* rtl/two_key_record_insertion_sorter.sv */
// Top level of the stable two-key record sorter built from a chain of cells.
//
//   channel   direction  word
//   rec_in    sink       post_code, phone_number, payload_tag, last_record
//   rec_out   source     post_code_res, phone_number_res, payload_tag_res,
//                        last_out, overflowed
//
// Loading takes one record per cycle: every cell compares its key pair with the
// incoming word at once and the chain opens a slot in the same cycle.
// After the word with last_record is taken, rec_in.ready stays low while the
// run drains from the head cell, one word per cycle, each stalled cycle on
// rec_out holding the chain. Reset empties every cell.
module two_key_record_insertion_sorter (
  input logic        clk,
  input logic        rst,
  tkis_in_if.sink    rec_in,
  tkis_out_if.source rec_out
);
  import tkis_pkg::*;

  record_t                cell_rec [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] cell_vld;
  logic [MAX_RECORDS-1:0] cell_after;
  record_t                new_rec;
  cell_ctrl_t             ctrl;
  logic                   draining;
  logic                   overflow;
  logic                   full;
  logic                   in_fire;
  logic                   out_fire;

  assign new_rec = '{post: rec_in.post_code, number: rec_in.phone_number,
                     tag: rec_in.payload_tag};

  assign full     = cell_vld[MAX_RECORDS-1];
  assign in_fire  = rec_in.valid && rec_in.ready;
  assign out_fire = rec_out.valid && rec_out.ready;

  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_fire;

  genvar i;
  generate
    for (i = 0; i < MAX_RECORDS; i++) begin : g_cell
      record_t lrec;
      logic    lvld;
      logic    laft;
      record_t rrec;
      logic    rvld;

      if (i == 0) begin : g_head
        assign lrec = new_rec;
        assign lvld = 1'b1;
        assign laft = 1'b0;
      end else begin : g_body
        assign lrec = cell_rec[i-1];
        assign lvld = cell_vld[i-1];
        assign laft = cell_after[i-1];
      end

      if (i == MAX_RECORDS-1) begin : g_tail
        assign rrec = '0;
        assign rvld = 1'b0;
      end else begin : g_inner
        assign rrec = cell_rec[i+1];
        assign rvld = cell_vld[i+1];
      end

      tkis_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .new_rec    (new_rec),
        .left_rec   (lrec),
        .left_valid (lvld),
        .left_after (laft),
        .right_rec  (rrec),
        .right_valid(rvld),
        .rec        (cell_rec[i]),
        .valid      (cell_vld[i]),
        .after      (cell_after[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      overflow <= 1'b0;
    end else if (out_fire && rec_out.last_out) begin
      draining <= 1'b0;
      overflow <= 1'b0;
    end else if (in_fire) begin
      if (rec_in.last_record) begin
        draining <= 1'b1;
      end
      if (full) begin
        overflow <= 1'b1;
      end
    end
  end

  assign rec_in.ready = !draining;

  assign rec_out.valid            = draining && cell_vld[0];
  assign rec_out.post_code_res    = cell_rec[0].post;
  assign rec_out.phone_number_res = cell_rec[0].number;
  assign rec_out.payload_tag_res  = cell_rec[0].tag;
  assign rec_out.last_out         = !cell_vld[1];
  assign rec_out.overflowed       = overflow;

  // Occupied cells always form an unbroken run from the head.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cell_vld + 1'b1) & cell_vld) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_grow: assert property (@(posedge clk) disable iff (rst)
    in_fire && !full |=> $countones(cell_vld) == $past($countones(cell_vld)) + 1)
    else $error("an accepted record did not take a cell");

  a_end: assert property (@(posedge clk) disable iff (rst)
    out_fire && rec_out.last_out |=> !rec_out.valid && cell_vld == '0)
    else $error("chain not empty after the final word of a run");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    rec_out.valid |-> !rec_in.ready)
    else $error("input taken while the sorted run drains");

endmodule

/* rtl/tkis_cell.sv */
// One sorter cell: holds a record, compares it with the incoming one and shifts.
module tkis_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  tkis_pkg::cell_ctrl_t ctrl,
  input  tkis_pkg::record_t    new_rec,
  input  tkis_pkg::record_t    left_rec,
  input  logic                 left_valid,
  input  logic                 left_after,
  input  tkis_pkg::record_t    right_rec,
  input  logic                 right_valid,
  output tkis_pkg::record_t    rec,
  output logic                 valid,
  output logic                 after
);
  import tkis_pkg::*;

  logic gt;

  // An empty cell counts as greater than any key, so empty cells sit at the tail.
  assign gt = (rec.post > new_rec.post) ||
              ((rec.post == new_rec.post) && (rec.number > new_rec.number));
  assign after = !valid || gt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right_valid;
    end else if (ctrl.insert && after) begin
      valid <= left_after ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      rec <= right_rec;
    end else if (ctrl.insert && after) begin
      rec <= left_after ? left_rec : new_rec;
    end
  end

endmodule

/* test/tb_two_key_record_insertion_sorter.sv */
// Testbench for the two-key record sorter: random and directed record sets checked against a model.
module tb_two_key_record_insertion_sorter;
  import tkis_pkg::*;

  typedef struct packed {
    record_t rec;
    logic    last;
    logic    ovf;
  } sorted_word_t;

  typedef enum {KEY_TIES, KEY_IN_RANGE, KEY_ANY_BITS} key_spread_e;

  logic clk = 1'b0;
  logic rst;

  tkis_in_if  rec_in_ch ();
  tkis_out_if rec_out_ch ();

  two_key_record_insertion_sorter dut (
    .clk     (clk),
    .rst     (rst),
    .rec_in  (rec_in_ch),
    .rec_out (rec_out_ch)
  );

  // Model of the sorter: its own copy of the store, kept in sorted order.
  record_t      model_store [MAX_RECORDS];
  int unsigned  model_held;
  bit           model_dropped;
  sorted_word_t expected_sorted [$];

  int unsigned failures;
  int unsigned random_sent;
  bit          steady_sender;
  bit          steady_receiver;
  bit          hold_request;
  int unsigned hold_left;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Insert one accepted record into the model and queue the sorted run when the set closes.
  function automatic void absorb_record(input record_t r, input bit closes);
    int unsigned  pos;
    sorted_word_t w;
    if (model_held < MAX_RECORDS) begin
      pos = model_held;
      // A new record goes after every stored record with an equal key pair.
      while (pos > 0 && ((model_store[pos-1].post > r.post) ||
             (model_store[pos-1].post == r.post && model_store[pos-1].number > r.number))) begin
        model_store[pos] = model_store[pos-1];
        pos--;
      end
      model_store[pos] = r;
      model_held++;
    end else begin
      model_dropped = 1'b1;
    end
    if (closes) begin
      for (int unsigned k = 0; k < model_held; k++) begin
        w.rec  = model_store[k];
        w.last = (k + 1 == model_held);
        w.ovf  = model_dropped;
        expected_sorted.push_back(w);
      end
      model_held    = 0;
      model_dropped = 1'b0;
    end
  endfunction

  function automatic record_t random_record(input key_spread_e spread);
    record_t     r;
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case (spread)
      KEY_TIES: begin
        r.post   = POST_W'($urandom_range(3));
        r.number = NUMBER_W'($urandom_range(3));
      end
      KEY_IN_RANGE: begin
        r.post   = POST_W'($urandom_range(999999));
        r.number = NUMBER_W'(wide % 64'd100000000000);
      end
      default: begin
        r.post   = POST_W'($urandom);
        r.number = wide[NUMBER_W-1:0];
      end
    endcase
    r.tag = TAG_W'($urandom);
    return r;
  endfunction

  // Offer one record word and wait until the sorter takes it.
  task automatic send_record(input record_t r, input bit closes);
    @(negedge clk);
    while (!steady_sender && $urandom_range(99) < 10) begin
      rec_in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rec_in_ch.valid        <= 1'b1;
    rec_in_ch.post_code    <= r.post;
    rec_in_ch.phone_number <= r.number;
    rec_in_ch.payload_tag  <= r.tag;
    rec_in_ch.last_record  <= closes;
    @(posedge clk);
    while (!rec_in_ch.ready) @(posedge clk);
    absorb_record(r, closes);
  endtask

  task automatic release_input();
    @(negedge clk);
    rec_in_ch.valid <= 1'b0;
  endtask

  task automatic send_set(input int unsigned n, input key_spread_e spread);
    for (int unsigned i = 0; i < n; i++) send_record(random_record(spread), i == n - 1);
  endtask

  task automatic wait_sorted_drained();
    while (expected_sorted.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, steady stretches, and a long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = 300;
    end
    if (hold_left > 0) begin
      rec_out_ch.ready <= 1'b0;
      hold_left--;
    end else if (steady_receiver) begin
      rec_out_ch.ready <= 1'b1;
    end else begin
      rec_out_ch.ready <= ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk) begin
    sorted_word_t got;
    sorted_word_t want;
    if (!rst && rec_out_ch.valid && rec_out_ch.ready) begin
      got.rec.post   = rec_out_ch.post_code_res;
      got.rec.number = rec_out_ch.phone_number_res;
      got.rec.tag    = rec_out_ch.payload_tag_res;
      got.last       = rec_out_ch.last_out;
      got.ovf        = rec_out_ch.overflowed;
      if (expected_sorted.size() == 0) begin
        $display("%0t: unexpected sorted word post=%0d number=%0d tag=%0d last=%b ovf=%b",
                 $time, got.rec.post, got.rec.number, got.rec.tag, got.last, got.ovf);
        failures++;
      end else begin
        want = expected_sorted.pop_front();
        if (got.rec.post !== want.rec.post || got.rec.number !== want.rec.number ||
            got.rec.tag !== want.rec.tag || got.last !== want.last || got.ovf !== want.ovf) begin
          $display("%0t: sorted word mismatch: expected post=%0d number=%0d tag=%0d last=%b ovf=%b",
                   $time, want.rec.post, want.rec.number, want.rec.tag, want.last, want.ovf);
          $display("%0t:                       actual   post=%0d number=%0d tag=%0d last=%b ovf=%b",
                   $time, got.rec.post, got.rec.number, got.rec.tag, got.last, got.ovf);
          failures++;
        end
      end
    end
  end

  // Extremes of every field, including values past the stated ranges and alternating bits.
  task automatic test_field_extremes();
    send_record('{post: '0, number: '0, tag: '0}, 1'b0);
    send_record('{post: '1, number: '1, tag: '1}, 1'b0);
    send_record('{post: 20'd999999, number: 37'd99999999999, tag: 16'hFFFF}, 1'b0);
    send_record('{post: 20'hAAAAA, number: 37'h0A_AAAA_AAAA, tag: 16'hAAAA}, 1'b0);
    send_record('{post: 20'h55555, number: 37'h15_5555_5555, tag: 16'h5555}, 1'b0);
    send_record('{post: 20'd999999, number: '0, tag: 16'd1}, 1'b1);
  endtask

  task automatic test_single_record();
    send_record('{post: 20'd123456, number: 37'd5551234567, tag: 16'h0042}, 1'b1);
  endtask

  // Equal key pairs must leave in arrival order; the phone number breaks ties of postal code.
  task automatic test_equal_keys_stable();
    send_record('{post: 20'd5, number: 37'd7, tag: 16'd1}, 1'b0);
    send_record('{post: 20'd5, number: 37'd7, tag: 16'd2}, 1'b0);
    send_record('{post: 20'd5, number: 37'd3, tag: 16'd3}, 1'b0);
    send_record('{post: 20'd2, number: 37'd9, tag: 16'd4}, 1'b0);
    send_record('{post: 20'd5, number: 37'd7, tag: 16'd5}, 1'b0);
    send_record('{post: 20'd5, number: 37'd3, tag: 16'd6}, 1'b0);
    send_record('{post: 20'd2, number: 37'd9, tag: 16'd7}, 1'b0);
    send_record('{post: 20'd5, number: 37'd7, tag: 16'd8}, 1'b1);
  endtask

  // A full store with no drop, a dropped closing word, and drops before the closing word.
  task automatic test_capacity();
    send_set(MAX_RECORDS, KEY_TIES);
    steady_sender   = 1'b1;
    steady_receiver = 1'b1;
    send_set(MAX_RECORDS + 1, KEY_IN_RANGE);
    steady_sender   = 1'b0;
    steady_receiver = 1'b0;
    send_set(MAX_RECORDS + 3, KEY_ANY_BITS);
    random_sent += 3 * MAX_RECORDS + 4;
  endtask

  // The receiver holds off while the next set is offered, so the input stalls during the drain.
  // Afterwards the sender waits for every result before it goes on.
  task automatic test_output_backpressure();
    steady_sender = 1'b1;
    send_set(5, KEY_TIES);
    hold_request = 1'b1;
    send_set(7, KEY_IN_RANGE);
    send_set(6, KEY_ANY_BITS);
    steady_sender = 1'b0;
    release_input();
    wait_sorted_drained();
    repeat (8) @(posedge clk);
    send_set(4, KEY_TIES);
  endtask

  task automatic test_random_sets();
    int unsigned n;
    while (random_sent < 160) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(20, MAX_RECORDS + 4) : $urandom_range(1, 8);
      steady_sender   = ($urandom_range(7) == 0);
      steady_receiver = steady_sender;
      send_set(n, key_spread_e'($urandom_range(2)));
      random_sent += n;
      if ($urandom_range(4) == 0) begin
        release_input();
        wait_sorted_drained();
      end
    end
    steady_sender   = 1'b0;
    steady_receiver = 1'b0;
  endtask

  initial begin
    rst                    = 1'b1;
    rec_in_ch.valid        = 1'b0;
    rec_in_ch.post_code    = '0;
    rec_in_ch.phone_number = '0;
    rec_in_ch.payload_tag  = '0;
    rec_in_ch.last_record  = 1'b0;
    rec_out_ch.ready       = 1'b0;
    model_held             = 0;
    model_dropped          = 1'b0;
    failures               = 0;
    random_sent            = 0;
    steady_sender          = 1'b0;
    steady_receiver        = 1'b0;
    hold_request           = 1'b0;
    hold_left              = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_field_extremes();
    test_single_record();
    test_equal_keys_stable();
    test_capacity();
    test_output_backpressure();
    test_random_sets();

    release_input();
    wait_sorted_drained();
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("FAIL");
    $finish;
  end

endmodule
